[rtl/tga_rle_pixel_decoder_macros.svh]
// Assertion macros for the Targa pixel decoder.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TGA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tga_pkg.sv]
// Types and constants for the Targa run-length pixel decoder.
`timescale 1ns / 1ps

package tga_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_COMPRESSED   = 2'd0;
    localparam logic [1:0] REG_HAS_ALPHA    = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

    // position within a pixel's color bytes
    localparam logic [1:0] PHASE_BLUE  = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_RED   = 2'd2;
    localparam logic [1:0] PHASE_ALPHA = 2'd3;

    localparam logic [7:0] HDR_RUN_BIT    = 8'h80;
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;
    localparam logic [7:0] OPAQUE_ALPHA   = 8'd255;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic [31:0] first_index;
        logic        image_done;
    } result_t;

endpackage

[rtl/tga_rle_pixel_decoder.sv]
// A result is registered at the edge that takes its last byte, in the head or skid entry.
// One byte per cycle while the skid entry is empty; each byte updates the state in one pass.
// A two-entry output buffer keeps input open while one result waits downstream.
// Reset (aresetn, synchronous, active low): registers go to compressed 32-bit 1x1,
// decode state clears, and the block drops bytes until an image start arrives.
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_macros.svh"

module tga_rle_pixel_decoder
    import tga_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_image_start,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic [7:0]  m_repeat_count,
    output logic [31:0] m_first_index,
    output logic        m_image_done
);

    // configuration
    logic        compressed_reg;
    logic        has_alpha_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;

    // decode state
    logic        expect_header_reg, expect_header_next;
    logic [1:0]  byte_phase_reg,    byte_phase_next;
    logic [7:0]  blue_hold_reg,     blue_hold_next;
    logic [7:0]  green_hold_reg,    green_hold_next;
    logic [7:0]  red_hold_reg,      red_hold_next;
    logic        packet_is_run_reg, packet_is_run_next;
    logic [7:0]  packet_left_reg,   packet_left_next;
    logic [31:0] pixels_emitted_reg, pixels_emitted_next;
    logic [31:0] pixels_left_reg,   pixels_left_next;
    logic        finished_reg,      finished_next;

    // output buffer
    logic        out_valid_reg;
    logic        skid_valid_reg;
    result_t     out_reg;
    result_t     skid_reg;

    logic        accept;
    logic        push;
    logic        pop;
    result_t     result;
    logic [31:0] image_area;
    logic [7:0]  count;
    logic [7:0]  pixel_alpha;
    logic [31:0] left_after;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    assign image_area = {16'd0, width_reg} * {16'd0, height_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compressed_reg <= 1'b1;
            has_alpha_reg  <= 1'b1;
            width_reg      <= 16'd1;
            height_reg     <= 16'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COMPRESSED:   compressed_reg <= cfg_data[0];
                REG_HAS_ALPHA:    has_alpha_reg  <= cfg_data[0];
                REG_IMAGE_WIDTH:  width_reg      <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        expect_header_next  = expect_header_reg;
        byte_phase_next     = byte_phase_reg;
        blue_hold_next      = blue_hold_reg;
        green_hold_next     = green_hold_reg;
        red_hold_next       = red_hold_reg;
        packet_is_run_next  = packet_is_run_reg;
        packet_left_next    = packet_left_reg;
        pixels_emitted_next = pixels_emitted_reg;
        pixels_left_next    = pixels_left_reg;
        finished_next       = finished_reg;
        push                = 1'b0;
        count               = 8'd1;
        pixel_alpha         = s_data_byte;
        left_after          = pixels_left_reg;
        result              = '0;

        if (accept) begin
            if (s_image_start) begin
                expect_header_next  = 1'b1;
                byte_phase_next     = PHASE_BLUE;
                blue_hold_next      = 8'd0;
                green_hold_next     = 8'd0;
                red_hold_next       = 8'd0;
                packet_is_run_next  = 1'b0;
                packet_left_next    = 8'd0;
                pixels_emitted_next = 32'd0;
                pixels_left_next    = image_area;
                finished_next       = (width_reg == 16'd0) || (height_reg == 16'd0);
            end

            if (!finished_next) begin
                if (compressed_reg && expect_header_next) begin
                    packet_is_run_next = (s_data_byte & HDR_RUN_BIT) != 8'd0;
                    packet_left_next   = (s_data_byte & HDR_COUNT_MASK) + 8'd1;
                    expect_header_next = 1'b0;
                    byte_phase_next    = PHASE_BLUE;
                end else begin
                    case (byte_phase_next)
                        PHASE_BLUE: begin
                            blue_hold_next  = s_data_byte;
                            byte_phase_next = PHASE_GREEN;
                        end
                        PHASE_GREEN: begin
                            green_hold_next = s_data_byte;
                            byte_phase_next = PHASE_RED;
                        end
                        PHASE_RED: begin
                            red_hold_next = s_data_byte;
                            if (has_alpha_reg) begin
                                byte_phase_next = PHASE_ALPHA;
                            end else begin
                                byte_phase_next = PHASE_BLUE;
                                pixel_alpha     = OPAQUE_ALPHA;
                                push            = 1'b1;
                            end
                        end
                        default: begin
                            // alpha byte, whatever has_alpha says now
                            byte_phase_next = PHASE_BLUE;
                            push            = 1'b1;
                        end
                    endcase

                    // a start byte never completes a pixel, so the registered
                    // pixel count is the one that applies here
                    if (push) begin
                        if (compressed_reg) begin
                            if (packet_is_run_reg) begin
                                count            = packet_left_reg;
                                packet_left_next = 8'd0;
                            end else if (packet_left_reg != 8'd0) begin
                                packet_left_next = packet_left_reg - 8'd1;
                            end
                            if (packet_left_next == 8'd0) begin
                                expect_header_next = 1'b1;
                            end
                        end
                        if ({24'd0, count} > pixels_left_reg) begin
                            count = pixels_left_reg[7:0];
                        end
                        left_after          = pixels_left_reg - {24'd0, count};
                        pixels_emitted_next = pixels_emitted_reg + {24'd0, count};
                        pixels_left_next    = left_after;
                        finished_next       = (left_after == 32'd0);

                        result.red          = red_hold_next;
                        result.green        = green_hold_reg;
                        result.blue         = blue_hold_reg;
                        result.alpha        = pixel_alpha;
                        result.repeat_count = count;
                        result.first_index  = pixels_emitted_reg;
                        result.image_done   = (left_after == 32'd0);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg  <= 1'b1;
            byte_phase_reg     <= PHASE_BLUE;
            blue_hold_reg      <= 8'd0;
            green_hold_reg     <= 8'd0;
            red_hold_reg       <= 8'd0;
            packet_is_run_reg  <= 1'b0;
            packet_left_reg    <= 8'd0;
            pixels_emitted_reg <= 32'd0;
            pixels_left_reg    <= 32'd0;
            finished_reg       <= 1'b1;
        end else begin
            expect_header_reg  <= expect_header_next;
            byte_phase_reg     <= byte_phase_next;
            blue_hold_reg      <= blue_hold_next;
            green_hold_reg     <= green_hold_next;
            red_hold_reg       <= red_hold_next;
            packet_is_run_reg  <= packet_is_run_next;
            packet_left_reg    <= packet_left_next;
            pixels_emitted_reg <= pixels_emitted_next;
            pixels_left_reg    <= pixels_left_next;
            finished_reg       <= finished_next;
        end
    end

    // two-entry output buffer: head register plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg) begin
                out_valid_reg <= push;
            end else if (pop) begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= 1'b0;
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        if (out_valid_reg && !pop && push) begin
            skid_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_red          = out_reg.red;
    assign m_green        = out_reg.green;
    assign m_blue         = out_reg.blue;
    assign m_alpha        = out_reg.alpha;
    assign m_repeat_count = out_reg.repeat_count;
    assign m_first_index  = out_reg.first_index;
    assign m_image_done   = out_reg.image_done;

    `TGA_ASSERT_SAME(a_skid_behind_head, aclk, aresetn, skid_valid_reg, out_valid_reg,
        "skid entry holds an item while the head register is empty")
    `TGA_ASSERT_NEXT(a_done_sets_finished, aclk, aresetn, push && result.image_done,
        finished_reg, "image completed but decoder still takes bytes")
    `TGA_ASSERT_SAME(a_active_has_pixels, aclk, aresetn, !finished_reg,
        pixels_left_reg != 32'd0, "image active with no pixels left")
    `TGA_ASSERT_SAME(a_no_item_when_finished, aclk, aresetn,
        accept && finished_reg && !s_image_start, !push,
        "result produced from a byte dropped after image end")

endmodule
